[rtl/core/trmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmd_pkg: shared types and constants of the ring mean downscaler
// Request types, lane and merge control, partial-sum entry layout,
// register indexes and the small constant tables.
// ----------------------------------------------------------------------------
package trmd_pkg;

	localparam int PART_SUM_W = 11;
	localparam int PART_CNT_W = 4;
	localparam int PART_W     = PART_SUM_W + PART_CNT_W;
	localparam int RECIP_SH   = 15;
	localparam int RECIP_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int BPR_W      = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_THR0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BPR  = 3'd4;

	localparam logic [3:0] RING_NONE = 4'd8;

	typedef struct packed {
		logic [31:0] pixel_word;
		logic        frame_start;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_pixel;
		logic        row_end;
	} out_item_t;

	typedef struct packed {
		logic [PART_CNT_W-1:0] cnt;
		logic [PART_SUM_W-1:0] sum;
	} partial_t;

	typedef struct packed {
		logic first;
		logic ring_act;
		logic capture;
		logic advance;
	} lane_ctrl_t;

	typedef struct packed {
		logic load;
		logic row_end;
	} merge_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RMW,
		ST_DIV1,
		ST_DIV2
	} state_t;

	function automatic logic [3:0] ring_pos(input logic [1:0] srow, input logic [1:0] scol);
		logic [3:0] rp;
		rp = RING_NONE;
		unique case ({srow, scol})
			4'b00_00: rp = 4'd0;
			4'b00_01: rp = 4'd1;
			4'b00_10: rp = 4'd2;
			4'b01_00: rp = 4'd3;
			4'b01_10: rp = 4'd4;
			4'b10_00: rp = 4'd5;
			4'b10_01: rp = 4'd6;
			4'b10_10: rp = 4'd7;
			default:  rp = RING_NONE;
		endcase
		return rp;
	endfunction

	// ceil(2^15 / d); exact floor for any 11-bit dividend
	function automatic logic [RECIP_W-1:0] recip(input logic [PART_CNT_W-1:0] d);
		logic [RECIP_W-1:0] r;
		r = '0;
		unique case (d)
			4'd1:    r = 16'd32768;
			4'd2:    r = 16'd16384;
			4'd3:    r = 16'd10923;
			4'd4:    r = 16'd8192;
			4'd5:    r = 16'd6554;
			4'd6:    r = 16'd5462;
			4'd7:    r = 16'd4682;
			4'd8:    r = 16'd4096;
			4'd9:    r = 16'd3641;
			4'd10:   r = 16'd3277;
			4'd11:   r = 16'd2979;
			4'd12:   r = 16'd2731;
			4'd13:   r = 16'd2521;
			4'd14:   r = 16'd2341;
			4'd15:   r = 16'd2185;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/trmd_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmd_lane: one byte channel of the downscaler
// Threshold compare and partial-sum update, then a two-stage rounded
// divide of the block sum by its count.
// ----------------------------------------------------------------------------
module trmd_lane (
	input  logic                 clk,
	input  trmd_pkg::lane_ctrl_t ctrl,
	input  logic [7:0]           pix_byte,
	input  logic [7:0]           thr_byte,
	input  trmd_pkg::partial_t   old_part,
	output trmd_pkg::partial_t   new_part,
	output logic [7:0]           mean
);
	import trmd_pkg::*;

	localparam int PROD_W = PART_SUM_W + RECIP_W;

	partial_t                base;
	logic                    hit;
	logic [PART_SUM_W-1:0]   sum_s1;
	logic [PART_CNT_W-1:0]   cnt_s1;
	logic [PROD_W-1:0]       prod_s2;
	logic [PART_SUM_W-1:0]   sum_s2;
	logic [PART_CNT_W-1:0]   cnt_s2;
	logic [PART_SUM_W-1:0]   quo;
	logic [PART_SUM_W+PART_CNT_W-1:0] back;
	logic [PART_SUM_W-1:0]   rem_full;
	logic [PART_CNT_W:0]     rem2;
	logic                    up;

	always_comb begin
		base = ctrl.first ? '0 : old_part;
		hit  = ctrl.ring_act && (pix_byte >= thr_byte);
		new_part = base;
		if (hit) begin
			new_part.sum = base.sum + PART_SUM_W'(pix_byte);
			new_part.cnt = base.cnt + PART_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			sum_s1 <= new_part.sum;
			cnt_s1 <= new_part.cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			prod_s2 <= PROD_W'(sum_s1) * PROD_W'(recip(cnt_s1));
			sum_s2  <= sum_s1;
			cnt_s2  <= cnt_s1;
		end
	end

	always_comb begin
		quo      = prod_s2[RECIP_SH +: PART_SUM_W];
		back     = (PART_SUM_W + PART_CNT_W)'(quo) * (PART_SUM_W + PART_CNT_W)'(cnt_s2);
		rem_full = sum_s2 - back[PART_SUM_W-1:0];
		rem2     = {rem_full[PART_CNT_W-1:0], 1'b0};
		up       = (rem2 > {1'b0, cnt_s2}) || ((rem2 == {1'b0, cnt_s2}) && quo[0]);
		mean     = (cnt_s2 == '0) ? 8'd0 : (quo[7:0] + 8'(up));
	end

endmodule

[rtl/core/trmd_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmd_merge: result assembly and output register
// Pack the lane means into one pixel and hold it until the request is taken.
// ----------------------------------------------------------------------------
module trmd_merge #(
	parameter int CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trmd_pkg::merge_ctrl_t         ctrl,
	input  logic [CHANNELS-1:0][7:0]      means,
	output logic                          ready,
	output logic                          valid,
	input  logic                          stall,
	output trmd_pkg::out_item_t           data
);
	import trmd_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign ready = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= 1'b1;
		end else if (valid_q && !stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q.out_pixel <= 32'(means);
			data_q.row_end   <= ctrl.row_end;
		end
	end

endmodule

[rtl/core/thresholded_ring_mean_downscale_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thresholded_ring_mean_downscale_unit: 3x3 thresholded ring mean downscaler
// Every pixel request first reads the column's partial-sum entry from the
// single-port partial memory and then, in ST_RMW, updates it and writes it
// back. The bottom-right pixel of a block then runs the reciprocal divide
// in the channel lanes (ST_DIV1, ST_DIV2), and waits further only while the
// output register still holds an untaken result. No clearing pass is run.
// ----------------------------------------------------------------------------
module thresholded_ring_mean_downscale_unit #(
	parameter int MAX_BLOCKS_PER_ROW = 1024,
	parameter int CHANNELS           = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  trmd_pkg::in_item_t                  pixel_data,
	output logic                                result_valid,
	input  logic                                result_stall,
	output trmd_pkg::out_item_t                 result_data,
	input  logic                                wr_en,
	input  logic [trmd_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [trmd_pkg::CFG_DATA_W-1:0]     wr_data
);
	import trmd_pkg::*;

	localparam int CW      = (MAX_BLOCKS_PER_ROW > 1) ? $clog2(MAX_BLOCKS_PER_ROW) : 1;
	localparam int LW      = (CW + 1 > BPR_W + 1) ? CW + 1 : BPR_W + 1;
	localparam int ENTRY_W = PART_W * CHANNELS;

	logic [CFG_DATA_W-1:0] thresholds_q [4];
	logic [BPR_W-1:0]      blocks_per_row_q;

	logic [CW-1:0] block_column_q;
	logic [1:0]    sub_column_q;
	logic [1:0]    sub_row_q;

	logic [31:0]   pix_q;
	logic [CW-1:0] col_q;
	logic [1:0]    srow_q;
	logic [1:0]    scol_q;
	logic          row_end_q;

	logic [ENTRY_W-1:0] part_mem [MAX_BLOCKS_PER_ROW];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [ENTRY_W-1:0] new_entry;

	state_t state_q, state_nxt;

	logic          accept;
	logic [LW-1:0] bpr_ext;
	logic [LW-1:0] eff_bpr;
	logic [CW-1:0] cur_bc;
	logic [1:0]    cur_sc;
	logic [1:0]    cur_sr;
	logic [LW-1:0] bc_inc;
	logic          row_last;
	logic [3:0]    rp;
	logic          last_px;
	logic          merge_ready;

	lane_ctrl_t            lane_ctrl;
	merge_ctrl_t           merge_ctrl;
	logic [CHANNELS-1:0][7:0] means;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				thresholds_q[i] <= '0;
			end
			blocks_per_row_q <= BPR_W'(1);
		end else if (wr_en) begin
			unique case (wr_index) inside
				CFG_THR0, CFG_THR1, CFG_THR2, CFG_THR3: begin
					thresholds_q[wr_index[1:0]] <= wr_data;
				end
				CFG_BPR: begin
					blocks_per_row_q <= wr_data[BPR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// position tracking
	assign accept = pixel_valid && !pixel_stall;

	always_comb begin
		bpr_ext = LW'(blocks_per_row_q);
		if (bpr_ext == '0) begin
			eff_bpr = LW'(1);
		end else if (bpr_ext > LW'(MAX_BLOCKS_PER_ROW)) begin
			eff_bpr = LW'(MAX_BLOCKS_PER_ROW);
		end else begin
			eff_bpr = bpr_ext;
		end
		cur_bc   = pixel_data.frame_start ? '0 : block_column_q;
		cur_sc   = pixel_data.frame_start ? 2'd0 : sub_column_q;
		cur_sr   = pixel_data.frame_start ? 2'd0 : sub_row_q;
		bc_inc   = LW'(cur_bc) + LW'(1);
		row_last = (bc_inc >= eff_bpr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_column_q <= '0;
			sub_column_q   <= 2'd0;
			sub_row_q      <= 2'd0;
		end else if (accept) begin
			if (cur_sc >= 2'd2) begin
				sub_column_q <= 2'd0;
				if (row_last) begin
					block_column_q <= '0;
					sub_row_q      <= (cur_sr >= 2'd2) ? 2'd0 : cur_sr + 2'd1;
				end else begin
					block_column_q <= bc_inc[CW-1:0];
					sub_row_q      <= cur_sr;
				end
			end else begin
				sub_column_q   <= cur_sc + 2'd1;
				block_column_q <= cur_bc;
				sub_row_q      <= cur_sr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q     <= pixel_data.pixel_word;
			col_q     <= cur_bc;
			srow_q    <= cur_sr;
			scol_q    <= cur_sc;
			row_end_q <= row_last;
		end
	end

	// partial-sum memory
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_q <= part_mem[cur_bc];
		end
		if (state_q == ST_RMW) begin
			part_mem[col_q] <= new_entry;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign rp      = ring_pos(srow_q, scol_q);
	assign last_px = (srow_q == 2'd2) && (scol_q == 2'd2);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept)      state_nxt = ST_RMW;
			ST_RMW:  state_nxt = last_px ? ST_DIV1 : ST_IDLE;
			ST_DIV1: state_nxt = ST_DIV2;
			ST_DIV2: if (merge_ready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		pixel_stall        = (state_q != ST_IDLE);
		lane_ctrl.first    = (srow_q == 2'd0) && (scol_q == 2'd0);
		lane_ctrl.ring_act = (rp != RING_NONE);
		lane_ctrl.capture  = (state_q == ST_RMW) && last_px;
		lane_ctrl.advance  = (state_q == ST_DIV1);
		merge_ctrl.load    = (state_q == ST_DIV2) && merge_ready;
		merge_ctrl.row_end = row_end_q;
	end

	// channel lanes
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		partial_t   new_part;
		logic [7:0] thr_byte;

		assign thr_byte = thresholds_q[c][{rp[2:0], 3'b000} +: 8];
		assign new_entry[c*PART_W +: PART_W] = new_part;

		trmd_lane u_lane (
			.clk      (clk),
			.ctrl     (lane_ctrl),
			.pix_byte (pix_q[8*c +: 8]),
			.thr_byte (thr_byte),
			.old_part (rd_data_q[c*PART_W +: PART_W]),
			.new_part (new_part),
			.mean     (means[c])
		);
	end

	trmd_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (merge_ctrl),
		.means  (means),
		.ready  (merge_ready),
		.valid  (result_valid),
		.stall  (result_stall),
		.data   (result_data)
	);

endmodule
